// File: sv/servo_pulse_normalizer_defines.svh
// assertion macros used by the checker file
`ifndef SERVO_PULSE_NORMALIZER_DEFINES_SVH
`define SERVO_PULSE_NORMALIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/spn_pkg.sv
package spn_pkg;

	// sizes
	localparam int NUM_CHANNELS_DEF = 5;
	localparam int NUM_PULSES       = 5;
	localparam int PULSE_W          = 12;
	localparam int END_W            = 14;
	localparam int POS_W            = 8;
	localparam int MAG_W            = 7;
	localparam int DIST_W           = 12;
	localparam int SPAN_W           = 14;
	localparam int PROD_W           = 19;
	localparam int QUOT_BITS        = 7;
	localparam int IDX_W            = 3;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;

	// scaling constants
	localparam int CLAMP_LOW  = 800;
	localparam int CLAMP_HIGH = 2300;
	localparam int SCALE_TOP  = 101;
	localparam int SCALE_MAX  = 100;

	// channel numbers
	localparam logic [3:0] CH_STEERING  = 4'd0;
	localparam logic [3:0] CH_THROTTLE  = 4'd1;
	localparam logic [3:0] CH_AUX_ONE   = 4'd2;
	localparam logic [3:0] CH_AUX_TWO   = 4'd3;
	localparam logic [3:0] CH_AUX_THREE = 4'd4;
	localparam logic [3:0] NUM_CAL_CH   = 4'd2;

	// action codes
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_FRAME = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENDPOINT_DELTA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_TICKS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MASK      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSED_MASK  = 3'd5;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_WAIT   = 2'd1,
		PH_NORMAL = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CAL,
		OP_NORM
	} frame_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_WRITE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_ITER
	} div_state_t;

	typedef struct packed {
		logic               action;
		logic [PULSE_W-1:0] pulse_steering;
		logic [PULSE_W-1:0] pulse_throttle;
		logic [PULSE_W-1:0] pulse_aux_one;
		logic [PULSE_W-1:0] pulse_aux_two;
		logic [PULSE_W-1:0] pulse_aux_three;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]        channel_index;
		logic signed [POS_W-1:0] position;
		logic [MAG_W-1:0]        magnitude;
		logic                    data_fresh;
		logic                    still_initializing;
		logic                    last_channel;
	} res_t;

	// one calibration and output record per channel
	typedef struct packed {
		logic signed [END_W-1:0] left_end;
		logic signed [END_W-1:0] centre_point;
		logic signed [END_W-1:0] right_end;
		logic signed [POS_W-1:0] last_position;
		logic [MAG_W-1:0]        last_magnitude;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [DIST_W-1:0] diff;
		logic [SPAN_W-1:0] span;
	} scale_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] value;
	} scale_rsp_t;

	// pulse of one channel, zero for channels past the input fields
	function automatic logic [PULSE_W-1:0] pulse_sel(cmd_t c, logic [3:0] ch);
		logic [PULSE_W-1:0] p;
		case (ch)
			CH_STEERING:  p = c.pulse_steering;
			CH_THROTTLE:  p = c.pulse_throttle;
			CH_AUX_ONE:   p = c.pulse_aux_one;
			CH_AUX_TWO:   p = c.pulse_aux_two;
			CH_AUX_THREE: p = c.pulse_aux_three;
			default:      p = '0;
		endcase
		return p;
	endfunction

endpackage

// File: sv/spn_mem.sv
module spn_mem import spn_pkg::*; #(
	parameter int DEPTH = NUM_CHANNELS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	output entry_t        rd_data
);

	entry_t           mem [DEPTH];
	entry_t           rd_word_q;
	logic [DEPTH-1:0] valid_q;
	logic             rd_hit_q;

	// storage array, one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// per-entry valid bits, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_word_q : '0;

endmodule

// File: sv/spn_scale.sv
module spn_scale import spn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  scale_req_t req,
	output scale_rsp_t rsp
);

	div_state_t             state_q, state_d;
	logic [PROD_W-1:0]      rem_q, rem_d;
	logic [SPAN_W-1:0]      span_q, span_d;
	logic [QUOT_BITS-1:0]   quot_q, quot_d;
	logic [2:0]             step_q, step_d;
	logic                   done_q, done_d;
	logic [MAG_W-1:0]       value_q, value_d;
	logic [PROD_W+1:0]      shifted;
	logic                   trial_ge;

	// state and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rem_q   <= rem_d;
		span_q  <= span_d;
		quot_q  <= quot_d;
		step_q  <= step_d;
		value_q <= value_d;
	end

	// restoring division, one quotient bit per cycle, saturating at 100
	always_comb begin
		state_d  = state_q;
		rem_d    = rem_q;
		span_d   = span_q;
		quot_d   = quot_q;
		step_d   = step_q;
		done_d   = 1'b0;
		value_d  = value_q;
		shifted  = {7'b0, span_q} << step_q;
		trial_ge = {2'b00, rem_q} >= shifted;
		case (state_q)
			DV_IDLE: begin
				if (req.start) begin
					rem_d   = {7'b0, req.diff} * PROD_W'(SCALE_TOP);
					span_d  = req.span;
					state_d = DV_CHECK;
				end
			end
			DV_CHECK: begin
				// quotient of 128 or more saturates at once
				if ({2'b00, rem_q} >= {span_q, 7'b0}) begin
					value_d = MAG_W'(SCALE_MAX);
					done_d  = 1'b1;
					state_d = DV_IDLE;
				end else begin
					quot_d  = '0;
					step_d  = 3'(QUOT_BITS - 1);
					state_d = DV_ITER;
				end
			end
			DV_ITER: begin
				if (trial_ge) begin
					rem_d = rem_q - shifted[PROD_W-1:0];
				end
				quot_d = {quot_q[QUOT_BITS-2:0], trial_ge};
				if (step_q == 3'd0) begin
					value_d = (quot_d > MAG_W'(SCALE_MAX)) ? MAG_W'(SCALE_MAX) : quot_d;
					done_d  = 1'b1;
					state_d = DV_IDLE;
				end else begin
					step_d = step_q - 3'd1;
				end
			end
			default: state_d = DV_IDLE;
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

// File: sv/servo_pulse_normalizer.sv
// RC pulse normalizer. A tick (action 0) leaves the sequencer idle and only
// counts the start-up timer down. A frame (action 1) gives NUM_CHANNELS
// results, one per channel in channel order, the last one flagged by
// last_channel. Each channel record sits in a small memory with one read and
// one write port and is read, updated and written back in turn (states READ,
// LOAD, WRITE); a channel that is scaled passes through DIV between LOAD and
// WRITE, where the shared divider produces seven quotient bits, one per
// cycle. No scaling is done in the first frame, waiting frames or the
// calibrating frame. cmd_stall stays high until the frame's last result has
// been handed to the output register. Configuration registers may be written
// at any time through cfg_valid/cfg_ready (always ready) but should only
// change while the block is idle.
module servo_pulse_normalizer import spn_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_t                  cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// configuration registers
	logic [PULSE_W-1:0]   pmin_q, pmax_q;
	logic [9:0]           delta_q;
	logic [15:0]          start_ticks_q;
	logic [NUM_PULSES-1:0] auto_q, rev_q;

	// frame level state
	phase_t      phase_q;
	logic [15:0] countdown_q;
	logic        init_q;
	frame_op_t   op_q;
	logic        fresh_q;
	cmd_t        cmd_q;

	// channel sequencer
	ctrl_state_t     state_q, state_d;
	logic [CH_W-1:0] ch_q, ch_d;
	entry_t          entry_q, entry_d;
	logic            neg_q, neg_d;
	logic [3:0]      ch_ext;
	logic            ch_last;

	// memory and divider
	logic       mem_rd, mem_wr;
	entry_t     mem_rdata;
	scale_req_t scale_req;
	scale_rsp_t scale_rsp;

	// output register
	logic res_valid_q;
	res_t res_q;
	logic res_free, res_load;

	// channel datapath
	logic [PULSE_W-1:0]   raw;
	logic [PULSE_W-1:0]   clamped;
	logic                 in_range;
	logic                 auto_bit, rev_bit;
	logic signed [14:0]   raw_s, cent_s, left_s, right_s, left_n, right_n;
	logic signed [14:0]   span_sel, dist_sel;
	logic                 lt, eq, neg_now;
	logic [END_W-1:0]     cal_left, cal_right;
	logic [POS_W-1:0]     sat_pos, div_pos;
	logic                 cmd_take;

	assign cmd_take  = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// config writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmin_q        <= PULSE_W'(600);
			pmax_q        <= PULSE_W'(2500);
			delta_q       <= 10'd200;
			start_ticks_q <= 16'd2000;
			auto_q        <= '0;
			rev_q         <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PULSE_MIN:      pmin_q        <= cfg_data[PULSE_W-1:0];
				CFG_PULSE_MAX:      pmax_q        <= cfg_data[PULSE_W-1:0];
				CFG_ENDPOINT_DELTA: delta_q       <= cfg_data[9:0];
				CFG_STARTUP_TICKS:  start_ticks_q <= cfg_data;
				CFG_AUTO_MASK:      auto_q        <= cfg_data[NUM_PULSES-1:0];
				CFG_REVERSED_MASK:  rev_q         <= cfg_data[NUM_PULSES-1:0];
				default: ;
			endcase
		end
	end

	// tick countdown and frame phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			countdown_q <= '0;
			init_q      <= 1'b1;
			op_q        <= OP_NONE;
			fresh_q     <= 1'b0;
		end else if (cmd_take) begin
			if (cmd.action == ACT_TICK) begin
				if (countdown_q != 16'd0) begin
					countdown_q <= countdown_q - 16'd1;
				end
			end else begin
				case (phase_q)
					PH_FIRST: begin
						countdown_q <= start_ticks_q;
						phase_q     <= PH_WAIT;
						op_q        <= OP_NONE;
						fresh_q     <= 1'b0;
					end
					PH_WAIT: begin
						if (countdown_q == 16'd0) begin
							phase_q <= PH_NORMAL;
							init_q  <= 1'b0;
							op_q    <= OP_CAL;
							fresh_q <= 1'b0;
						end else begin
							op_q    <= OP_NONE;
							fresh_q <= 1'b1;
						end
					end
					PH_NORMAL: begin
						op_q    <= OP_NORM;
						fresh_q <= 1'b1;
					end
					default: begin
						phase_q <= PH_FIRST;
						op_q    <= OP_NONE;
						fresh_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// frame payload
	always_ff @(posedge clk) begin
		if (cmd_take && cmd.action == ACT_FRAME) begin
			cmd_q <= cmd;
		end
	end

	// per-channel selects
	assign ch_ext   = 4'(ch_q);
	assign ch_last  = (ch_q == CH_W'(NUM_CHANNELS - 1));
	assign raw      = pulse_sel(cmd_q, ch_ext);
	assign auto_bit = (ch_ext < 4'(NUM_PULSES)) ? auto_q[ch_ext[2:0]] : 1'b0;
	assign rev_bit  = (ch_ext < 4'(NUM_PULSES)) ? rev_q[ch_ext[2:0]] : 1'b0;

	// range check and clamp
	assign in_range = (raw >= pmin_q) && (raw <= pmax_q);
	assign clamped  = (raw < PULSE_W'(CLAMP_LOW))  ? PULSE_W'(CLAMP_LOW) :
	                  (raw > PULSE_W'(CLAMP_HIGH)) ? PULSE_W'(CLAMP_HIGH) : raw;

	// endpoint arithmetic on the record just read
	assign raw_s   = {3'b000, clamped};
	assign cent_s  = {mem_rdata.centre_point[END_W-1], mem_rdata.centre_point};
	assign left_s  = {mem_rdata.left_end[END_W-1], mem_rdata.left_end};
	assign right_s = {mem_rdata.right_end[END_W-1], mem_rdata.right_end};
	assign lt      = raw_s < cent_s;
	assign eq      = raw_s == cent_s;
	assign left_n  = (auto_bit && raw_s < left_s) ? raw_s : left_s;
	assign right_n = (auto_bit && raw_s > right_s) ? raw_s : right_s;
	assign span_sel = lt ? (cent_s - left_n) : (right_n - cent_s);
	assign dist_sel = lt ? (cent_s - raw_s) : (raw_s - cent_s);
	assign neg_now  = lt ? !rev_bit : rev_bit;
	assign sat_pos  = neg_now ? (8'd0 - POS_W'(SCALE_MAX)) : POS_W'(SCALE_MAX);
	assign div_pos  = neg_q ? (8'd0 - {1'b0, scale_rsp.value}) : {1'b0, scale_rsp.value};

	// centre calibration
	assign cal_left  = {2'b00, raw} - {4'b0000, delta_q};
	assign cal_right = {2'b00, raw} + {4'b0000, delta_q};

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		neg_q   <= neg_d;
	end

	// read, update, write back each channel record in turn
	always_comb begin
		state_d   = state_q;
		ch_d      = ch_q;
		entry_d   = entry_q;
		neg_d     = neg_q;
		mem_rd    = 1'b0;
		mem_wr    = 1'b0;
		res_load  = 1'b0;
		scale_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_take && cmd.action == ACT_FRAME) begin
					ch_d    = '0;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				mem_rd  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				entry_d = mem_rdata;
				state_d = ST_WRITE;
				case (op_q)
					OP_CAL: begin
						if (ch_ext < NUM_CAL_CH) begin
							entry_d.centre_point = {2'b00, raw};
							entry_d.left_end     = cal_left;
							entry_d.right_end    = cal_right;
						end
					end
					OP_NORM: begin
						if (!in_range) begin
							// invalid pulse keeps the last value unless auto mode
							if (auto_bit) begin
								entry_d.last_position  = '0;
								entry_d.last_magnitude = '0;
							end
						end else if (eq) begin
							entry_d.last_position  = '0;
							entry_d.last_magnitude = '0;
						end else begin
							entry_d.left_end  = left_n[END_W-1:0];
							entry_d.right_end = right_n[END_W-1:0];
							neg_d             = neg_now;
							if (span_sel > 15'sd0) begin
								scale_req.start = 1'b1;
								scale_req.diff  = dist_sel[DIST_W-1:0];
								scale_req.span  = span_sel[SPAN_W-1:0];
								state_d         = ST_DIV;
							end else begin
								// zero or negative span saturates
								entry_d.last_position  = sat_pos;
								entry_d.last_magnitude = MAG_W'(SCALE_MAX);
							end
						end
					end
					default: ;
				endcase
			end
			ST_DIV: begin
				if (scale_rsp.done) begin
					entry_d.last_position  = div_pos;
					entry_d.last_magnitude = scale_rsp.value;
					state_d                = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (res_free) begin
					mem_wr   = 1'b1;
					res_load = 1'b1;
					if (ch_last) begin
						state_d = ST_IDLE;
					end else begin
						ch_d    = ch_q + CH_W'(1);
						state_d = ST_READ;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// channel records, read and written one at a time so accesses never overlap
	spn_mem #(
		.DEPTH (NUM_CHANNELS),
		.AW    (CH_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd),
		.rd_addr (ch_q),
		.wr_en   (mem_wr),
		.wr_addr (ch_q),
		.wr_data (entry_q),
		.rd_data (mem_rdata)
	);

	// shared scaling divider
	spn_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scale_req),
		.rsp    (scale_rsp)
	);

	// result register
	assign res_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.channel_index      <= IDX_W'(ch_q);
			res_q.position           <= entry_q.last_position;
			res_q.magnitude          <= entry_q.last_magnitude;
			res_q.data_fresh         <= fresh_q;
			res_q.still_initializing <= init_q;
			res_q.last_channel       <= ch_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: sv/spn_checker.sv
`include "servo_pulse_normalizer_defines.svh"

module spn_checker import spn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// a stalled result stays offered
	`SPN_ASSERT_NEXT(a_res_hold, (res_valid && res_stall), res_valid, "result dropped while stalled")

	// position and magnitude agree and stay in range
	`SPN_ASSERT_NOW(a_res_range, res_valid, ((res.magnitude <= 7'd100) && ((res.position == {1'b0, res.magnitude}) || ((8'd0 - res.position) == {1'b0, res.magnitude}))), "position and magnitude disagree")

	// a frame keeps the input side busy
	`SPN_ASSERT_NEXT(a_frame_busy, (cmd_valid && !cmd_stall && cmd.action == ACT_FRAME), cmd_stall, "frame accepted without going busy")

	// a tick does not hold the input side
	`SPN_ASSERT_NEXT(a_tick_quick, (cmd_valid && !cmd_stall && cmd.action == ACT_TICK), !cmd_stall, "tick held the input side")

	// while a result other than the last is offered, the frame is still running
	`SPN_ASSERT_NOW(a_mid_frame, (res_valid && !res.last_channel), cmd_stall, "input side free in the middle of a frame")

endmodule

bind servo_pulse_normalizer spn_checker u_spn_checker (.*);
